// ----- hw/rtl/swdf_pkg.sv -----
package swdf_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 256;
  localparam int unsigned ID_W      = 32;
  localparam int unsigned FILL_W    = 9;
  localparam int unsigned REG_W     = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned LH_W      = FILL_W + 1;

  localparam logic [REG_W-1:0] MIN_LIMIT   = REG_W'(20);
  localparam logic [REG_W-1:0] MIN_CUT     = REG_W'(1);
  localparam logic [REG_W-1:0] LIMIT_RESET = REG_W'(200);
  localparam logic [REG_W-1:0] CUT_RESET   = REG_W'(20);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LIMIT  = 8'd0,
    REG_DISCARD_COUNT = 8'd1
  } reg_idx_e;

  typedef enum logic [3:0] {
    U_IDLE   = 4'd0,
    U_RD_LO  = 4'd1,
    U_RD_HI  = 4'd2,
    U_LD_HI  = 4'd3,
    U_LOOP   = 4'd4,
    U_PROBE  = 4'd5,
    U_REFILL = 4'd6,
    U_RELOAD = 4'd7,
    U_FINAL  = 4'd8,
    U_CHECK  = 4'd9,
    U_INSERT = 4'd10,
    U_WAIT   = 4'd11,
    U_EMIT   = 4'd12
  } upc_e;

  typedef enum logic [2:0] {
    RD_NONE, RD_LO, RD_HI, RD_MID, RD_DIR
  } rd_sel_e;

  typedef enum logic [1:0] {
    LD_NONE, LD_LV, LD_HV, LD_DIR
  } ld_sel_e;

  typedef enum logic [2:0] {
    OP_NONE, OP_ACCEPT, OP_PROBE, OP_CHECK, OP_INSERT, OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_IN, C_EMPTY, C_NO_LOOP, C_HIT, C_LO_GT_HI,
    C_LO_OUT, C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    rd_sel_e rd;
    ld_sel_e ld;
    op_e     op;
    cond_e   cond;
    upc_e    jmp;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic empty;
    logic loop_ok;
    logic hit;
    logic lo_gt_hi;
    logic lo_out;
    logic out_busy;
  } stat_t;

  // microprogram: read data is registered and lands in the step after its address is issued
  function automatic ctrl_t ucode(upc_e pc);
    ctrl_t cw;
    cw = '{RD_NONE, LD_NONE, OP_NONE, C_NEVER, U_IDLE};
    case (pc)
      U_IDLE:   cw = '{RD_NONE, LD_NONE, OP_ACCEPT, C_NO_IN,    U_IDLE};
      U_RD_LO:  cw = '{RD_LO,   LD_NONE, OP_NONE,   C_EMPTY,    U_INSERT};
      U_RD_HI:  cw = '{RD_HI,   LD_LV,   OP_NONE,   C_NEVER,    U_IDLE};
      U_LD_HI:  cw = '{RD_NONE, LD_HV,   OP_NONE,   C_NEVER,    U_IDLE};
      U_LOOP:   cw = '{RD_MID,  LD_NONE, OP_NONE,   C_NO_LOOP,  U_FINAL};
      U_PROBE:  cw = '{RD_NONE, LD_NONE, OP_PROBE,  C_HIT,      U_INSERT};
      U_REFILL: cw = '{RD_DIR,  LD_NONE, OP_NONE,   C_LO_GT_HI, U_LOOP};
      U_RELOAD: cw = '{RD_NONE, LD_DIR,  OP_NONE,   C_ALWAYS,   U_LOOP};
      U_FINAL:  cw = '{RD_LO,   LD_NONE, OP_NONE,   C_LO_OUT,   U_INSERT};
      U_CHECK:  cw = '{RD_NONE, LD_NONE, OP_CHECK,  C_NEVER,    U_IDLE};
      U_INSERT: cw = '{RD_NONE, LD_NONE, OP_INSERT, C_NEVER,    U_IDLE};
      U_WAIT:   cw = '{RD_NONE, LD_NONE, OP_NONE,   C_OUT_BUSY, U_WAIT};
      U_EMIT:   cw = '{RD_NONE, LD_NONE, OP_EMIT,   C_ALWAYS,   U_IDLE};
      default:  cw = '{RD_NONE, LD_NONE, OP_NONE,   C_ALWAYS,   U_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ----- hw/rtl/swdf_if.sv -----
interface swdf_in_if;
  import swdf_pkg::*;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] msg_id;
  modport source (output valid, output msg_id, input ready);
  modport sink   (input valid, input msg_id, output ready);
endinterface

interface swdf_out_if;
  import swdf_pkg::*;
  logic              valid;
  logic              ready;
  logic              is_duplicate;
  logic [FILL_W-1:0] fill_level;
  modport source (output valid, output is_duplicate, output fill_level, input ready);
  modport sink   (input valid, input is_duplicate, input fill_level, output ready);
endinterface

interface swdf_cfg_if;
  import swdf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/swdf_useq.sv -----
module swdf_useq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  swdf_pkg::stat_t stat_i,
  output swdf_pkg::ctrl_t ctrl_o
);
  import swdf_pkg::*;

  upc_e  upc_q, upc_d;
  ctrl_t cw;
  logic  take;

  always_comb begin
    cw = ucode(upc_q);
  end

  always_comb begin
    case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !stat_i.in_valid;
      C_EMPTY:    take = stat_i.empty;
      C_NO_LOOP:  take = !stat_i.loop_ok;
      C_HIT:      take = stat_i.hit;
      C_LO_GT_HI: take = stat_i.lo_gt_hi;
      C_LO_OUT:   take = stat_i.lo_out;
      C_OUT_BUSY: take = stat_i.out_busy;
      default:    take = 1'b0;
    endcase
    upc_d = take ? cw.jmp : upc_e'(upc_q + 4'd1);
  end

  assign ctrl_o = cw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ----- hw/rtl/swdf_datapath.sv -----
module swdf_datapath #(
  parameter int unsigned WINDOW_DEPTH = swdf_pkg::WINDOW_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  swdf_pkg::ctrl_t ctrl_i,
  output swdf_pkg::stat_t stat_o,
  swdf_in_if.sink         in_i,
  swdf_out_if.source      out_o,
  swdf_cfg_if.sink        cfg_i
);
  import swdf_pkg::*;

  localparam int unsigned PW = $clog2(WINDOW_DEPTH);
  localparam int unsigned SW = ((PW > FILL_W) ? PW : FILL_W) + 1;

  function automatic logic [PW-1:0] wrap(logic [PW-1:0] p, logic [FILL_W-1:0] idx);
    logic [SW-1:0] s;
    s = SW'(p) + SW'(idx);
    if (s >= SW'(WINDOW_DEPTH)) begin
      s = s - SW'(WINDOW_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  logic [ID_W-1:0] mem [WINDOW_DEPTH];
  logic [ID_W-1:0] rd_q;

  logic [REG_W-1:0]  limit_q, cut_q;
  logic [FILL_W-1:0] count_q, count_d;
  logic [PW-1:0]     ptr_q, ptr_d;
  logic              out_valid_q, out_valid_d;
  logic              out_dup_q;
  logic [FILL_W-1:0] out_fill_q;

  logic [ID_W-1:0]        id_q, lv_q, hv_q;
  logic signed [LH_W-1:0] lo_q, hi_q;
  logic                   dup_q, dir_lo_q;

  logic [LH_W:0]      mid_sum;
  logic [FILL_W-1:0]  mid;
  logic [FILL_W-1:0]  rd_idx;
  logic               rd_en;
  logic               we;
  logic [PW-1:0]      waddr;
  logic [FILL_W-1:0]  ins_count;
  logic [PW-1:0]      ins_ptr;
  logic [REG_W-1:0]   lim, cut;
  logic [FILL_W-1:0]  cut_n;
  logic               in_beat, out_beat;

  assign in_i.ready         = (ctrl_i.op == OP_ACCEPT);
  assign in_beat            = in_i.valid && in_i.ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.is_duplicate = out_dup_q;
  assign out_o.fill_level   = out_fill_q;
  assign out_beat           = out_valid_q && out_o.ready;
  assign cfg_i.ready        = 1'b1;

  // lo <= hi inside the loop, so both are non-negative there
  assign mid_sum = {lo_q[LH_W-1], lo_q} + {hi_q[LH_W-1], hi_q};
  assign mid     = mid_sum[FILL_W:1];

  assign lim = (limit_q < MIN_LIMIT) ? MIN_LIMIT : limit_q;
  assign cut = (cut_q < MIN_CUT) ? MIN_CUT : cut_q;

  always_comb begin
    stat_o.in_valid = in_i.valid;
    stat_o.empty    = (count_q == '0);
    stat_o.loop_ok  = (lo_q <= hi_q) && (lv_q <= id_q) && (hv_q >= id_q);
    stat_o.hit      = (rd_q == id_q);
    stat_o.lo_gt_hi = (lo_q > hi_q);
    stat_o.lo_out   = (lo_q >= $signed({1'b0, count_q}));
    stat_o.out_busy = out_valid_q && !out_o.ready;
  end

  always_comb begin
    rd_en  = 1'b1;
    rd_idx = lo_q[FILL_W-1:0];
    case (ctrl_i.rd)
      RD_LO:   rd_idx = lo_q[FILL_W-1:0];
      RD_HI:   rd_idx = hi_q[FILL_W-1:0];
      RD_MID:  rd_idx = mid;
      RD_DIR:  rd_idx = dir_lo_q ? lo_q[FILL_W-1:0] : hi_q[FILL_W-1:0];
      default: rd_en  = 1'b0;
    endcase
  end

  // insertion and trimming
  always_comb begin
    we        = 1'b0;
    waddr     = wrap(ptr_q, count_q);
    ins_count = count_q;
    ins_ptr   = ptr_q;
    if (32'(count_q) >= WINDOW_DEPTH) begin
      waddr   = ptr_q;
      ins_ptr = wrap(ptr_q, FILL_W'(1));
    end else begin
      ins_count = count_q + FILL_W'(1);
    end
    if (ctrl_i.op == OP_INSERT && !dup_q) begin
      we = 1'b1;
    end

    cut_n       = (FILL_W'(cut) > count_q) ? count_q : FILL_W'(cut);
    count_d     = count_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !out_beat;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (!dup_q) begin
          count_d = ins_count;
          ptr_d   = ins_ptr;
        end
      end
      OP_EMIT: begin
        if (count_q > FILL_W'(lim)) begin
          count_d = count_q - cut_n;
          ptr_d   = wrap(ptr_q, cut_n);
        end
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= id_q;
    end
    if (rd_en) begin
      rd_q <= mem[wrap(ptr_q, rd_idx)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LIMIT_RESET;
      cut_q       <= CUT_RESET;
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_WINDOW_LIMIT:  limit_q <= cfg_i.data;
          REG_DISCARD_COUNT: cut_q   <= cfg_i.data;
          default: ;
        endcase
      end
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      id_q  <= in_i.msg_id;
      lo_q  <= '0;
      hi_q  <= $signed({1'b0, count_q}) - LH_W'(1);
      dup_q <= 1'b0;
    end
    case (ctrl_i.ld)
      LD_LV:  lv_q <= rd_q;
      LD_HV:  hv_q <= rd_q;
      LD_DIR: begin
        if (dir_lo_q) begin
          lv_q <= rd_q;
        end else begin
          hv_q <= rd_q;
        end
      end
      default: ;
    endcase
    case (ctrl_i.op)
      OP_PROBE: begin
        if (rd_q == id_q) begin
          dup_q <= 1'b1;
        end else if (rd_q < id_q) begin
          lo_q     <= $signed({1'b0, mid}) + LH_W'(1);
          dir_lo_q <= 1'b1;
        end else begin
          hi_q     <= $signed({1'b0, mid}) - LH_W'(1);
          dir_lo_q <= 1'b0;
        end
      end
      OP_CHECK: begin
        if (rd_q == id_q) begin
          dup_q <= 1'b1;
        end
      end
      OP_EMIT: begin
        out_dup_q  <= dup_q;
        out_fill_q <= count_d;
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/sliding_window_duplicate_filter.sv -----
// Duplicate ID filter over a sliding window of recently seen IDs, held oldest first in a
// circular RAM of WINDOW_DEPTH words. Each ID beat is looked up by binary search and yields
// one result beat (duplicate flag, fill after the beat); a new ID is appended and, once the
// fill passes window_limit, the oldest discard_count entries are dropped in one go. A small
// microprogram steps a single RAM read port with registered read data: an item in an empty
// window goes straight to insertion; otherwise it runs up to 9 search probes (for 256
// entries), may make a final check and waits for the result register to drain if needed.
// The next ID is taken while the previous result still waits. Configuration is to be written
// by the user only while idle; the block itself does not enforce it.
module sliding_window_duplicate_filter #(
  parameter int unsigned WINDOW_DEPTH = swdf_pkg::WINDOW_DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  swdf_in_if.sink    in_i,
  swdf_out_if.source out_o,
  swdf_cfg_if.sink   cfg_i
);
  import swdf_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  swdf_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  swdf_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i)
  );

endmodule
